// ===== rtl/clcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, command codes and constants of the character LCD terminal
// sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

    localparam int MAX_COLS   = 20;
    localparam int MAX_ROWS   = 4;
    localparam int MAX_PARAMS = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    localparam int M_DATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STARTS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_SHOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_BLINK = 3'd4;

    localparam logic [27:0] ROW_STARTS_RESET = 28'd176496640;

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;

    localparam logic [10:0] WAIT_INSTR = 11'd37;
    localparam logic [10:0] WAIT_DATA  = 11'd41;
    localparam logic [10:0] WAIT_CLEAR = 11'd1677;

    localparam logic [5:0] TAB_STEP = 6'd4;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_J        = 8'h4A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_CLEAR,
        EM_HOME,
        EM_ADDR,
        EM_SPACE,
        EM_CHAR
    } emit_t;

    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_HOME,
        CUR_NEXT_ROW,
        CUR_COL0,
        CUR_INC,
        CUR_TAB,
        CUR_SET
    } cur_op_t;

    typedef enum logic [2:0] {
        K_ESC_SEQ,
        K_CR,
        K_LF,
        K_ESC,
        K_TAB,
        K_CHAR
    } kind_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_SET
    } esc_act_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic    load;
        emit_t   emit;
        cur_op_t cur_op;
        logic    last;
        logic    esc_step;
        logic    esc_enter;
        logic    nlp_set;
        logic    nlp_clr;
        logic    sp_clr;
    } dp_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        kind_t    kind;
        esc_act_t act;
        logic     main_emits;
        logic     pre_clear;
        logic     pre_newline;
        logic     lf_now;
        logic     wrap;
        logic     space_last;
        logic     out_free;
    } dp_stat_t;

    // Value modulo a row count of 1 to 4. Three rows use a reciprocal multiply
    // with one correction step.
    function automatic logic [1:0] mod_rows(input logic [8:0] v, input logic [2:0] rows);
        logic [19:0] prod;
        logic [8:0]  q;
        logic [8:0]  r;
        logic [1:0]  res;
        prod = {11'd0, v} * 20'd683;
        q    = prod[19:11];
        r    = v - 9'(q * 9'd3);
        if (r >= 9'd3) begin
            r = r - 9'd3;
        end
        case (rows)
            3'd1:    res = 2'd0;
            3'd2:    res = {1'b0, v[0]};
            3'd3:    res = r[1:0];
            default: res = v[1:0];
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/char_lcd_terminal_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_terminal_sequencer
// Text stream to character LCD bus transfers with cursor and escape handling.
// ----------------------------------------------------------------------------
// One character is taken at a time. Each character passes in order through
// the latch, the pre-write clear check (which also carries the clear
// transfer when one is due), the deferred newline check and the dispatch on
// the character kind. After that the sequencer steps through one bus transfer
// a state while the output side keeps up, with a cursor-move state ahead of
// the address transfer of a wrap, a set-cursor sequence or a newline. A
// newline that is carried out adds a row move and 23 transfers at a 20-column
// width. The pace is set by the single output register, which takes one
// transfer per cycle while the output side keeps up, and the sequencer, which
// steps through one transfer per state. Output stalls hold the sequencer in
// place. tdata of each result carries the LCD byte in bits 7:0 and the wait in
// microseconds in bits 18:8.
// ----------------------------------------------------------------------------
module char_lcd_terminal_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Character input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // char_code
    input  logic [1:0]                          s_tuser,   // first_of_write, pending_clear
    input  logic                                s_tlast,   // last_of_write
    // Bus transfer output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [clcd_pkg::M_DATA_W-1:0]       m_tdata,   // bus_byte, wait_us, zero pad
    output logic [0:0]                          m_tuser,   // to_data_register
    output logic                                m_tlast    // last
);
    import clcd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    clcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clcd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    // One character at a time: the input closes right after it accepts a character.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a character was in progress");

    // Instruction transfers are address, clear or home commands.
    a_instr_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            (m_tdata[7] || m_tdata[7:0] == CMD_CLEAR || m_tdata[7:0] == CMD_HOME))
        else $error("unexpected instruction byte");

    // Waits follow the transfer kind.
    a_wait_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            (m_tuser[0] && m_tdata[18:8] == WAIT_DATA) ||
            (!m_tuser[0] && m_tdata[7:0] == CMD_CLEAR && m_tdata[18:8] == WAIT_CLEAR) ||
            (!m_tuser[0] && m_tdata[7:0] != CMD_CLEAR && m_tdata[18:8] == WAIT_INSTR))
        else $error("wait does not match transfer kind");

endmodule

// ===== rtl/clcd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_ctrl
// Sequencer of the terminal: walks each character through pre-write clear,
// deferred newline and the character's own action, at most one bus transfer a step.
// ----------------------------------------------------------------------------
module clcd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  clcd_pkg::dp_stat_t stat,
    output clcd_pkg::dp_cmd_t  cmd
);
    import clcd_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLR    = 4'd1;
    localparam logic [3:0] ST_PRE    = 4'd2;
    localparam logic [3:0] ST_MAIN   = 4'd3;
    localparam logic [3:0] ST_CHAR   = 4'd4;
    localparam logic [3:0] ST_WRAP   = 4'd5;
    localparam logic [3:0] ST_ADDR   = 4'd6;
    localparam logic [3:0] ST_JCLR   = 4'd7;
    localparam logic [3:0] ST_JHOME  = 4'd8;
    localparam logic [3:0] ST_SETCUR = 4'd9;
    localparam logic [3:0] ST_NLROW  = 4'd10;
    localparam logic [3:0] ST_NLA1   = 4'd11;
    localparam logic [3:0] ST_NLA2   = 4'd12;
    localparam logic [3:0] ST_NLSP   = 4'd13;
    localparam logic [3:0] ST_NLA3   = 4'd14;

    logic [3:0] state_reg, state_next;
    // Set while the newline being written is the deferred one from a prior write.
    logic       pre_reg, pre_next;
    dp_cmd_t    c;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        c          = '0;
        state_next = state_reg;
        pre_next   = pre_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    c.load     = 1'b1;
                    state_next = ST_CLR;
                end
            end
            ST_CLR: begin
                if (stat.pre_clear) begin
                    c.emit   = EM_CLEAR;
                    c.cur_op = CUR_HOME;
                    c.last   = !stat.pre_newline && !stat.main_emits;
                end
                state_next = ST_PRE;
            end
            ST_PRE: begin
                if (stat.pre_newline) begin
                    c.nlp_clr  = 1'b1;
                    pre_next   = 1'b1;
                    state_next = ST_NLROW;
                end else begin
                    state_next = ST_MAIN;
                end
            end
            ST_MAIN: begin
                case (stat.kind)
                    K_ESC_SEQ: begin
                        c.esc_step = 1'b1;
                        case (stat.act)
                            ACT_CLEAR: state_next = ST_JCLR;
                            ACT_SET:   state_next = ST_SETCUR;
                            default:   state_next = ST_IDLE;
                        endcase
                    end
                    K_CR: begin
                        c.cur_op   = CUR_COL0;
                        state_next = ST_ADDR;
                    end
                    K_LF: begin
                        if (stat.lf_now) begin
                            pre_next   = 1'b0;
                            state_next = ST_NLROW;
                        end else begin
                            c.nlp_set  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    K_ESC: begin
                        c.esc_enter = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    K_TAB: begin
                        c.cur_op   = CUR_TAB;
                        state_next = ST_ADDR;
                    end
                    default: begin
                        state_next = ST_CHAR;
                    end
                endcase
            end
            ST_CHAR: begin
                c.emit     = EM_CHAR;
                c.cur_op   = CUR_INC;
                c.last     = !stat.wrap;
                state_next = stat.wrap ? ST_WRAP : ST_IDLE;
            end
            ST_WRAP: begin
                c.cur_op   = CUR_NEXT_ROW;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                c.emit     = EM_ADDR;
                c.last     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_JCLR: begin
                c.emit     = EM_CLEAR;
                c.cur_op   = CUR_HOME;
                state_next = ST_JHOME;
            end
            ST_JHOME: begin
                c.emit     = EM_HOME;
                c.cur_op   = CUR_HOME;
                c.last     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SETCUR: begin
                c.cur_op   = CUR_SET;
                state_next = ST_ADDR;
            end
            ST_NLROW: begin
                c.cur_op   = CUR_NEXT_ROW;
                c.sp_clr   = 1'b1;
                state_next = ST_NLA1;
            end
            ST_NLA1: begin
                c.emit     = EM_ADDR;
                state_next = ST_NLA2;
            end
            ST_NLA2: begin
                c.emit     = EM_ADDR;
                state_next = ST_NLSP;
            end
            ST_NLSP: begin
                c.emit = EM_SPACE;
                if (stat.space_last) begin
                    state_next = ST_NLA3;
                end
            end
            ST_NLA3: begin
                c.emit     = EM_ADDR;
                c.last     = pre_reg ? !stat.main_emits : 1'b1;
                state_next = pre_reg ? ST_MAIN : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A transfer step waits until the output register can take it.
        if (c.emit != EM_NONE && !stat.out_free) begin
            c          = '0;
            state_next = state_reg;
            pre_next   = pre_reg;
        end
    end

    assign cmd = c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pre_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            pre_reg   <= pre_next;
        end
    end

endmodule

// ===== rtl/clcd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_dp
// Datapath of the terminal: configuration registers, cursor, escape parser,
// character latch and the output register of the transfer stream.
// ----------------------------------------------------------------------------
module clcd_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [7:0]                          s_tdata,
    input  logic [1:0]                          s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [clcd_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    input  clcd_pkg::dp_cmd_t                   cmd,
    output clcd_pkg::dp_stat_t                  stat
);
    import clcd_pkg::*;

    // Configuration.
    logic [4:0]  columns_reg;
    logic [2:0]  row_count_reg;
    logic [27:0] row_starts_reg;
    logic        cursor_shown_reg;
    logic        cursor_blink_reg;

    // Cursor and deferred newline.
    logic [1:0]  row_reg, row_next;
    logic [4:0]  col_reg, col_next;
    logic        nlp_reg;

    // Escape parser.
    logic        esc_reg;
    logic        in_params_reg;
    logic [7:0]  dv_reg;
    logic        seen_reg;
    logic [2:0]  pc_reg;
    logic        err_reg;
    logic [7:0]  pv0_reg;
    logic [7:0]  pv1_reg;
    logic [7:0]  tr_reg;
    logic [7:0]  tc_reg;

    // Latched character.
    logic [7:0]  ch_reg;
    logic        first_reg;
    logic        lastw_reg;
    logic        dirty_reg;

    logic [4:0]  sp_cnt_reg;

    logic        m_valid_reg;
    logic        m_dr_reg;
    logic [7:0]  m_byte_reg;
    logic [10:0] m_wait_reg;
    logic        m_last_reg;

    logic [4:0]  ecols;
    logic [2:0]  erows;
    logic        cursor_off;
    logic        is_digit;
    logic [11:0] digit_t;
    logic [7:0]  digit_sat;
    logic        close_store;
    logic        close_err;
    logic        err_n;
    logic [2:0]  pc_n;
    logic [7:0]  pv0_n;
    logic [7:0]  pv1_n;
    esc_act_t    act;
    kind_t       kind;
    logic        main_emits;
    logic [6:0]  row_start;
    logic [6:0]  addr_sum;
    logic [1:0]  row_adv;
    logic [5:0]  tab_col;
    logic        out_free;
    logic        fire;
    logic [7:0]  em_byte;
    logic [10:0] em_wait;
    logic        em_dr;

    assign cfg_ready = 1'b1;

    assign ecols = (columns_reg == 5'd0) ? 5'd1 :
                   (columns_reg > 5'(MAX_COLS)) ? 5'(MAX_COLS) : columns_reg;
    assign erows = (row_count_reg == 3'd0) ? 3'd1 :
                   (row_count_reg > 3'(MAX_ROWS)) ? 3'(MAX_ROWS) : row_count_reg;
    assign cursor_off = !cursor_shown_reg && !cursor_blink_reg;

    // Escape parameter arithmetic.
    assign is_digit    = ch_reg inside {[CH_ZERO:CH_NINE]};
    assign digit_t     = ({4'd0, dv_reg} << 3) + ({4'd0, dv_reg} << 1) + {8'd0, ch_reg[3:0]};
    assign digit_sat   = (digit_t > 12'd255) ? 8'd255 : digit_t[7:0];
    assign close_store = seen_reg && (pc_reg < 3'(MAX_PARAMS));
    assign close_err   = seen_reg && (pc_reg >= 3'(MAX_PARAMS));
    assign err_n       = err_reg || close_err;
    assign pc_n        = close_store ? pc_reg + 3'd1 : pc_reg;
    assign pv0_n       = (close_store && pc_reg == 3'd0) ? dv_reg : pv0_reg;
    assign pv1_n       = (close_store && pc_reg == 3'd1) ? dv_reg : pv1_reg;

    // A final byte acts only when the parameter list closed without error.
    always_comb begin
        act = ACT_NONE;
        if (esc_reg && in_params_reg && !is_digit && ch_reg != CH_SEMI && !err_n) begin
            if (ch_reg == CH_J && pc_n == 3'd1 && pv0_n == 8'd2) begin
                act = ACT_CLEAR;
            end else if (ch_reg == CH_H && pc_n == 3'd2) begin
                act = ACT_SET;
            end
        end
    end

    always_comb begin
        if (esc_reg) begin
            kind = K_ESC_SEQ;
        end else begin
            case (ch_reg)
                CH_CR:   kind = K_CR;
                CH_LF:   kind = K_LF;
                CH_ESC:  kind = K_ESC;
                CH_TAB:  kind = K_TAB;
                default: kind = K_CHAR;
            endcase
        end
    end

    always_comb begin
        case (kind)
            K_ESC_SEQ: main_emits = (act != ACT_NONE);
            K_LF:      main_emits = cursor_off && !lastw_reg;
            K_ESC:     main_emits = 1'b0;
            default:   main_emits = 1'b1;
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;

    assign stat.kind        = kind;
    assign stat.act         = act;
    assign stat.main_emits  = main_emits;
    assign stat.pre_clear   = first_reg && dirty_reg;
    assign stat.pre_newline = first_reg && cursor_off && nlp_reg;
    assign stat.lf_now      = cursor_off && !lastw_reg;
    assign stat.wrap        = (col_reg + 5'd1) >= ecols;
    assign stat.space_last  = (sp_cnt_reg == ecols - 5'd1);
    assign stat.out_free    = out_free;

    // Display RAM address of the cursor.
    always_comb begin
        case (row_reg)
            2'd0:    row_start = row_starts_reg[6:0];
            2'd1:    row_start = row_starts_reg[13:7];
            2'd2:    row_start = row_starts_reg[20:14];
            default: row_start = row_starts_reg[27:21];
        endcase
    end
    assign addr_sum = row_start + {2'd0, col_reg};

    assign row_adv = mod_rows({7'd0, row_reg} + 9'd1, erows);
    assign tab_col = {1'b0, col_reg} + TAB_STEP;

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        case (cmd.cur_op)
            CUR_HOME: begin
                row_next = 2'd0;
                col_next = 5'd0;
            end
            CUR_NEXT_ROW: begin
                row_next = row_adv;
                col_next = 5'd0;
            end
            CUR_COL0: begin
                col_next = 5'd0;
            end
            CUR_INC: begin
                col_next = col_reg + 5'd1;
            end
            CUR_TAB: begin
                if (tab_col >= {1'b0, ecols}) begin
                    row_next = row_adv;
                    col_next = 5'd0;
                end else begin
                    col_next = tab_col[4:0];
                end
            end
            CUR_SET: begin
                // A column past the width moves to the start of the next row.
                if (tc_reg >= {3'd0, ecols}) begin
                    row_next = mod_rows({1'b0, tr_reg} + 9'd1, erows);
                    col_next = 5'd0;
                end else begin
                    row_next = (tr_reg >= {5'd0, erows}) ? 2'd0 : tr_reg[1:0];
                    col_next = tc_reg[4:0];
                end
            end
            default: begin
                row_next = row_reg;
                col_next = col_reg;
            end
        endcase
    end

    always_comb begin
        em_dr   = 1'b0;
        em_byte = CMD_SET_ADDR | {1'b0, addr_sum};
        em_wait = WAIT_INSTR;
        case (cmd.emit)
            EM_CLEAR: begin
                em_byte = CMD_CLEAR;
                em_wait = WAIT_CLEAR;
            end
            EM_HOME: begin
                em_byte = CMD_HOME;
            end
            EM_SPACE: begin
                em_dr   = 1'b1;
                em_byte = CH_SPACE;
                em_wait = WAIT_DATA;
            end
            EM_CHAR: begin
                em_dr   = 1'b1;
                em_byte = ch_reg;
                em_wait = WAIT_DATA;
            end
            default: begin
                em_dr = 1'b0;
            end
        endcase
    end

    assign fire = (cmd.emit != EM_NONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg      <= 5'(MAX_COLS);
            row_count_reg    <= 3'(MAX_ROWS);
            row_starts_reg   <= ROW_STARTS_RESET;
            cursor_shown_reg <= 1'b1;
            cursor_blink_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COLUMNS:      columns_reg      <= cfg_data[4:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg_data[2:0];
                REG_ROW_STARTS:   row_starts_reg   <= cfg_data;
                REG_CURSOR_SHOWN: cursor_shown_reg <= cfg_data[0];
                REG_CURSOR_BLINK: cursor_blink_reg <= cfg_data[0];
                default:          columns_reg      <= columns_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= 2'd0;
            col_reg <= 5'd0;
            nlp_reg <= 1'b0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (cmd.nlp_set) begin
                nlp_reg <= 1'b1;
            end else if (cmd.nlp_clr) begin
                nlp_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg       <= 1'b0;
            in_params_reg <= 1'b0;
            dv_reg        <= 8'd0;
            seen_reg      <= 1'b0;
            pc_reg        <= 3'd0;
            err_reg       <= 1'b0;
            pv0_reg       <= 8'd0;
            pv1_reg       <= 8'd0;
        end else if (cmd.esc_enter) begin
            esc_reg <= 1'b1;
        end else if (cmd.esc_step) begin
            if (!in_params_reg) begin
                if (ch_reg == CH_LBRACKET) begin
                    in_params_reg <= 1'b1;
                end
            end else if (is_digit) begin
                dv_reg   <= digit_sat;
                seen_reg <= 1'b1;
            end else if (ch_reg == CH_SEMI) begin
                err_reg <= err_n;
                pc_reg  <= pc_n;
                pv0_reg <= pv0_n;
                pv1_reg <= pv1_n;
                if (close_store) begin
                    dv_reg   <= 8'd0;
                    seen_reg <= 1'b0;
                end
            end else begin
                esc_reg       <= 1'b0;
                in_params_reg <= 1'b0;
                dv_reg        <= 8'd0;
                seen_reg      <= 1'b0;
                pc_reg        <= 3'd0;
                err_reg       <= 1'b0;
                pv0_reg       <= 8'd0;
                pv1_reg       <= 8'd0;
            end
        end
    end

    // Cursor target of a set-cursor sequence, captured as the parser clears.
    always_ff @(posedge aclk) begin
        if (cmd.esc_step) begin
            tr_reg <= pv0_n;
            tc_reg <= pv1_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg    <= s_tdata;
            first_reg <= s_tuser[0];
            dirty_reg <= s_tuser[1];
            lastw_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sp_clr) begin
            sp_cnt_reg <= 5'd0;
        end else if (cmd.emit == EM_SPACE) begin
            sp_cnt_reg <= sp_cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_dr_reg   <= em_dr;
            m_byte_reg <= em_byte;
            m_wait_reg <= em_wait;
            m_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_wait_reg, m_byte_reg};
    assign m_tuser  = m_dr_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== test/char_lcd_terminal_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_terminal_sequencer_test
// Self-checking bench for the character LCD terminal sequencer. A scoreboard
// carries its own model of the cursor, the deferred newline and the escape
// parser. It predicts the bus transfers for every character the block takes.
// Directed text comes first. Random text follows in phases, each phase under
// its own register setting. Both stream sides idle at random until the last
// phase, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module char_lcd_terminal_sequencer_test;
    import clcd_pkg::*;

    localparam int MAX_XFERS_PER_CHAR = 47;
    localparam int SETTLE_CYCLES      = 20;
    localparam int HOLD_CYCLES        = 400;
    localparam int WATCHDOG_LIMIT     = 3000;
    localparam int CHARS_PER_PHASE    = 24;
    localparam int PHASES             = 6;

    typedef struct packed {
        logic        to_data;
        logic [7:0]  bus_byte;
        logic [10:0] wait_us;
        logic        last;
    } lcd_xfer_t;

    // Mirrors the register copy, the cursor and the escape parser. It turns
    // each accepted character into the LCD transfers it should produce.
    class lcd_xfer_board;
        lcd_xfer_t   expected_xfers[$];
        lcd_xfer_t   batch[$];
        int          errors;
        int          xfers_checked;
        int unsigned width_reg, rows_reg;
        logic [27:0] row_starts;
        bit          show, blink;
        int unsigned row, col;
        bit          nl_pending, in_escape, in_params, have_digit, bad_params;
        int unsigned digit_acc, n_params;
        int unsigned params[2];

        function new();
            errors        = 0;
            xfers_checked = 0;
            width_reg     = MAX_COLS;
            rows_reg      = MAX_ROWS;
            row_starts    = ROW_STARTS_RESET;
            show          = 1'b1;
            blink         = 1'b1;
            row           = 0;
            col           = 0;
            nl_pending    = 1'b0;
            drop_escape();
        endfunction

        function int pending();
            return expected_xfers.size();
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_COLUMNS:      width_reg  = val[4:0];
                REG_ROW_COUNT:    rows_reg   = val[2:0];
                REG_ROW_STARTS:   row_starts = val[27:0];
                REG_CURSOR_SHOWN: show       = val[0];
                REG_CURSOR_BLINK: blink      = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned cols_used();
            if (width_reg == 0) return 1;
            return (width_reg > MAX_COLS) ? MAX_COLS : width_reg;
        endfunction

        function int unsigned rows_used();
            if (rows_reg == 0) return 1;
            return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        endfunction

        function void push_xfer(logic dr, logic [7:0] bb, logic [10:0] wu);
            lcd_xfer_t x;
            if (batch.size() >= MAX_XFERS_PER_CHAR) return;
            x.to_data  = dr;
            x.bus_byte = bb;
            x.wait_us  = wu;
            x.last     = 1'b0;
            batch.push_back(x);
        endfunction

        function void addr_xfer();
            logic [27:0] shifted;
            logic [6:0]  ram_addr;
            shifted  = row_starts >> (7 * (row & 3));
            ram_addr = shifted[6:0] + col[6:0];
            push_xfer(1'b0, CMD_SET_ADDR | {1'b0, ram_addr}, WAIT_INSTR);
        endfunction

        function void clear_xfer();
            push_xfer(1'b0, CMD_CLEAR, WAIT_CLEAR);
            row = 0;
            col = 0;
        endfunction

        function void step_row();
            row = ((row + 1) % rows_used()) & 3;
            col = 0;
        endfunction

        // Moves to the next row and blanks it, leaving the cursor at its start.
        function void blank_next_line();
            int unsigned n;
            n = cols_used();
            step_row();
            addr_xfer();
            addr_xfer();
            for (int unsigned i = 0; i < n; i++) push_xfer(1'b1, CH_SPACE, WAIT_DATA);
            addr_xfer();
        endfunction

        function void drop_escape();
            in_escape  = 1'b0;
            in_params  = 1'b0;
            digit_acc  = 0;
            have_digit = 1'b0;
            n_params   = 0;
            bad_params = 1'b0;
            params[0]  = 0;
            params[1]  = 0;
        endfunction

        function void escape_char(logic [7:0] code);
            int unsigned r, c, rows;
            if (!in_params) begin
                if (code == CH_LBRACKET) in_params = 1'b1;
                return;
            end
            if (code >= CH_ZERO && code <= CH_NINE) begin
                digit_acc  = digit_acc * 10 + (code - CH_ZERO);
                if (digit_acc > 255) digit_acc = 255;
                have_digit = 1'b1;
                return;
            end
            // A separator or a final byte closes a parameter that has digits.
            if (have_digit) begin
                if (n_params >= MAX_PARAMS) begin
                    bad_params = 1'b1;
                end else begin
                    if (n_params < 2) params[n_params] = digit_acc;
                    n_params   = (n_params + 1) & 7;
                    digit_acc  = 0;
                    have_digit = 1'b0;
                end
            end
            if (code == CH_SEMI) return;
            if (!bad_params) begin
                if (code == CH_J && n_params == 1 && params[0] == 2) begin
                    clear_xfer();
                    push_xfer(1'b0, CMD_HOME, WAIT_INSTR);
                end else if (code == CH_H && n_params == 2) begin
                    rows = rows_used();
                    r    = params[0];
                    c    = params[1];
                    if (c >= cols_used()) begin
                        r = (r + 1) % rows;
                        c = 0;
                    end
                    if (r >= rows) r = 0;
                    row = r & 3;
                    col = c & 31;
                    addr_xfer();
                end
            end
            drop_escape();
        endfunction

        function void note_char(logic [7:0] code, logic first, logic lastw, logic dirty);
            bit          cursor_off;
            int unsigned c;
            cursor_off = !show && !blink;
            batch.delete();
            if (first) begin
                if (dirty) clear_xfer();
                if (cursor_off && nl_pending) begin
                    nl_pending = 1'b0;
                    blank_next_line();
                end
            end
            if (in_escape) begin
                escape_char(code);
            end else if (code == CH_CR) begin
                col = 0;
                addr_xfer();
            end else if (code == CH_LF) begin
                if (cursor_off && !lastw) blank_next_line();
                else nl_pending = 1'b1;
            end else if (code == CH_ESC) begin
                in_escape = 1'b1;
            end else if (code == CH_TAB) begin
                c = col + TAB_STEP;
                if (c >= cols_used()) step_row();
                else col = c & 31;
                addr_xfer();
            end else begin
                push_xfer(1'b1, code, WAIT_DATA);
                col = (col + 1) & 31;
                if (col >= cols_used()) begin
                    step_row();
                    addr_xfer();
                end
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) expected_xfers.push_back(batch[i]);
        endfunction

        function void check_xfer(logic dr, logic [7:0] bb, logic [10:0] wu, logic lt);
            lcd_xfer_t want;
            if (expected_xfers.size() == 0) begin
                $error("unexpected LCD transfer: to_data_register=%0b bus_byte=0x%02h wait_us=%0d",
                       dr, bb, wu);
                errors++;
                return;
            end
            want = expected_xfers.pop_front();
            xfers_checked++;
            if (dr !== want.to_data) begin
                $error("to_data_register: expected %0b, got %0b", want.to_data, dr);
                errors++;
            end
            if (bb !== want.bus_byte) begin
                $error("bus_byte: expected 0x%02h, got 0x%02h", want.bus_byte, bb);
                errors++;
            end
            if (wu !== want.wait_us) begin
                $error("wait_us: expected %0d, got %0d", want.wait_us, wu);
                errors++;
            end
            if (lt !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, lt);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // char_code
    logic [1:0]            s_tuser;   // first_of_write, pending_clear
    logic                  s_tlast;   // last_of_write
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // bus_byte, wait_us, zero pad
    logic [0:0]            m_tuser;   // to_data_register
    logic                  m_tlast;   // last

    lcd_xfer_board board;
    bit            gaps_on;
    bit            stalls_on;
    bit            hold_output;
    int            write_left;
    int            chars_sent;
    int            settings_done;
    int            idle_cycles = 0;

    char_lcd_terminal_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // All handshakes are sampled here, so register writes, characters and
    // transfers reach the scoreboard in a fixed order within an edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) board.note_char(s_tdata, s_tuser[0], s_tlast, s_tuser[1]);
            if (m_tvalid && m_tready) begin
                board.check_xfer(m_tuser[0], m_tdata[7:0], m_tdata[18:8], m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("char_lcd_terminal_sequencer_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_output = 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [4:0] cols, input logic [2:0] rows,
                                input logic [27:0] starts, input logic shown,
                                input logic blinking);
        write_reg(REG_COLUMNS, {23'd0, cols});
        write_reg(REG_ROW_COUNT, {25'd0, rows});
        write_reg(REG_ROW_STARTS, starts);
        write_reg(REG_CURSOR_SHOWN, {27'd0, shown});
        write_reg(REG_CURSOR_BLINK, {27'd0, blinking});
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic send_char(input logic [7:0] code, input logic first, input logic lastw,
                             input logic dirty);
        s_tdata  <= code;
        s_tuser  <= {dirty, first};
        s_tlast  <= lastw;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
    endtask

    // Groups the text into write calls of 1 to 8 characters.
    task automatic send_text(input logic [7:0] code);
        logic first;
        first = (write_left == 0);
        if (first) write_left = $urandom_range(1, 8);
        write_left--;
        send_char(code, first, write_left == 0, $urandom_range(0, 7) == 0);
    endtask

    task automatic send_text_str(input string s);
        for (int i = 0; i < s.len(); i++) send_text(s[i]);
    endtask

    task automatic send_param(input int unsigned limit);
        send_text_str($sformatf("%0d", $urandom_range(0, limit)));
    endtask

    // Mostly well-formed sequences, with some that break off or misuse parameters.
    task automatic send_escape();
        int unsigned pick, n;
        send_text(CH_ESC);
        if ($urandom_range(0, 5) == 0) send_text(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) return;
        send_text(CH_LBRACKET);
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            send_text_str(($urandom_range(0, 3) == 0) ? "002" : "2");
            send_text(CH_J);
        end else if (pick < 7) begin
            send_param(($urandom_range(0, 7) == 0) ? 999 : 5);
            send_text(CH_SEMI);
            send_param(($urandom_range(0, 7) == 0) ? 999 : 24);
            send_text(CH_H);
        end else begin
            n = $urandom_range(0, 6);
            for (int unsigned i = 0; i < n; i++) begin
                if ($urandom_range(0, 4) != 0) send_param(($urandom_range(0, 3) == 0) ? 999 : 9);
                send_text(CH_SEMI);
            end
            case ($urandom_range(0, 2))
                0:       send_text(CH_J);
                1:       send_text(CH_H);
                default: send_text(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic send_token();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      send_text(8'($urandom_range(CH_SPACE, 8'h7E)));
        else if (pick < 55) send_text(8'($urandom_range(0, 255)));
        else if (pick < 63) send_text(CH_LF);
        else if (pick < 68) send_text(CH_CR);
        else if (pick < 73) send_text(CH_TAB);
        else                send_escape();
    endtask

    // Waits until every predicted transfer has come out, then lets a character
    // that causes no transfer finish inside the block.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        board         = new();
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        s_tlast       = 1'b0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        hold_output   = 1'b0;
        write_left    = 0;
        chars_sent    = 0;
        settings_done = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset geometry with the cursor on: a dirty start, byte extremes,
        // tab, carriage return and a newline that stays deferred.
        send_char("A", 1'b1, 1'b0, 1'b1);
        send_char(8'hFF, 1'b0, 1'b0, 1'b0);
        send_char(8'h00, 1'b0, 1'b0, 1'b1);
        send_char(CH_TAB, 1'b0, 1'b0, 1'b0);
        send_char(CH_CR, 1'b0, 1'b0, 1'b0);
        send_char(CH_LF, 1'b0, 1'b1, 1'b0);
        send_text(CH_ESC);
        send_text_str("[2J");
        // The column is past the width, so the cursor lands at the next row.
        send_text(CH_ESC);
        send_text_str("[3;20H");
        settle();

        // With the cursor off, the deferred newline runs at the next write start.
        program_regs(5'd20, 3'd4, ROW_STARTS_RESET, 1'b0, 1'b0);
        send_char("B", 1'b1, 1'b0, 1'b0);
        send_char(CH_LF, 1'b0, 1'b0, 1'b0);
        send_char("z", 1'b0, 1'b1, 1'b0);
        write_left = 0;
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: program_regs(5'd0, 3'd0, 28'hFFFFFFF, 1'b0, 1'b0);
                1: program_regs(5'd31, 3'd7, 28'($urandom_range(0, 28'hFFFFFFF)), 1'b1, 1'b0);
                2: program_regs(5'd1, 3'd1, 28'h0, 1'b0, 1'b1);
                3: program_regs(5'd20, 3'd4, ROW_STARTS_RESET, 1'b0, 1'b0);
                4: program_regs(5'($urandom_range(1, 20)), 3'($urandom_range(1, 4)),
                                28'($urandom_range(0, 28'hFFFFFFF)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                default: program_regs(5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                                      28'($urandom_range(0, 28'hFFFFFFF)),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            // Blank lines in this phase let the held output back up into the input.
            if (phase == 3) hold_output = 1'b1;
            if (phase == PHASES - 1) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            begin
                int goal;
                goal = chars_sent + CHARS_PER_PHASE;
                while (chars_sent < goal) send_token();
            end
            settle();
        end

        $display("Sent %0d characters under %0d register settings; checked %0d LCD transfers.",
                 chars_sent, settings_done, board.xfers_checked);
        $display("Text included clears, newlines, tabs, wraps, cursor escapes and a long stall.");
        if (board.errors == 0) begin
            $display("char_lcd_terminal_sequencer_test: PASS");
        end else begin
            $display("char_lcd_terminal_sequencer_test: FAIL");
        end
        $finish;
    end

endmodule
